@@ rtl/hps_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hps_pkg: shared types, constants and helpers
// Widths, angle constants and register indexes of the heading controller.
// ----------------------------------------------------------------------------
package hps_pkg;

    localparam int INTEGRAL_WIDTH = 48;
    localparam int GAIN_FRAC_BITS = 16;

    localparam int GAIN_W   = 24;
    localparam int ANGLE_W  = 16;
    localparam int SLEW_W   = 20;
    localparam int DT_W     = 16;
    localparam int DRIVE_W  = 32;
    localparam int ABSERR_W = 15;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Serial multiplier: wide operand A, shifted operand B.
    localparam int MUL_A_W = INTEGRAL_WIDTH;
    localparam int MUL_B_W = GAIN_W;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int QUOT_W  = PROD_W + 8;
    localparam int TERM_W  = 64;
    localparam int SUM_W   = TERM_W + 2;
    localparam int DIV_W   = 32;

    localparam int FULL_TURN = 46080;
    localparam int HALF_TURN = 23040;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GOAL   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SLEW   = 3'd4;

    localparam logic [QUOT_W-1:0] TERM_LIMIT = QUOT_W'(1) << 61;

    typedef logic signed [ANGLE_W:0] angle_diff_t;

    // Wrap a difference of two in-range angles to the half-turn band.
    function automatic angle_diff_t hps_wrap(input angle_diff_t e);
        angle_diff_t r;
        r = e;
        if (e > angle_diff_t'(HALF_TURN))
            r = e - angle_diff_t'(FULL_TURN);
        else if (e < -angle_diff_t'(HALF_TURN))
            r = e + angle_diff_t'(FULL_TURN);
        return r;
    endfunction

    // Signed floor of a shifted magnitude product, clamped in magnitude.
    function automatic logic signed [TERM_W-1:0] hps_term(input logic [QUOT_W-1:0] q,
                                                          input logic rem,
                                                          input logic neg);
        logic [QUOT_W-1:0] m;
        logic [TERM_W-1:0] mt;
        if (q > TERM_LIMIT)
            m = TERM_LIMIT;
        else if (neg && rem && (q < TERM_LIMIT))
            m = q + QUOT_W'(1);
        else
            m = q;
        mt = m[TERM_W-1:0];
        return neg ? -$signed(mt) : $signed(mt);
    endfunction

endpackage

@@ rtl/hps_item_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hps_item_if: input item channel
// Valid/ready channel carrying the time step and the measured heading.
// ----------------------------------------------------------------------------
interface hps_item_if;
    logic        valid;
    logic        ready;
    logic [15:0] step_time;
    logic [15:0] measured_heading;

    modport source (output valid, output step_time, output measured_heading, input ready);
    modport sink   (input valid, input step_time, input measured_heading, output ready);
endinterface

@@ rtl/hps_result_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hps_result_if: result channel
// Valid/ready channel carrying the drive and the error magnitude.
// ----------------------------------------------------------------------------
interface hps_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] drive;
    logic [14:0]        abs_error;

    modport source (output valid, output drive, output abs_error, input ready);
    modport sink   (input valid, input drive, input abs_error, output ready);
endinterface

@@ rtl/hps_cfg_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hps_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and its write data.
// ----------------------------------------------------------------------------
interface hps_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [23:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/heading_pid_with_slewed_target_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heading_pid_with_slewed_target_top: heading PID with a slewed setpoint
// Sequential PID controller built around a bit-serial multiplier and a
// bit-serial restoring divider.
// ----------------------------------------------------------------------------
// One item is worked on at a time. From the input transfer to the result
// being valid, five products pass in turn through the shared bit-serial
// multiplier (slew reach, integral increment, and the P, I and D terms),
// with hand-overs between them for the slewing, the error and the final
// sum. The derivative divide runs one quotient bit per cycle alongside the
// multiplier and adds no time. The result sits in an output register, so
// the next item is accepted in the cycle after the previous result has been
// loaded there, even if it has not yet been taken.
// A result that is still waiting when the next one is ready holds the block
// in its final state until it has been taken.
// Configuration writes are always accepted and take effect at once; they
// should be made only while the block is idle.
// ----------------------------------------------------------------------------
module heading_pid_with_slewed_target_top
    import hps_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    hps_item_if.sink      req,
    hps_result_if.source  rsp,
    hps_cfg_if.sink       cfg
);

    typedef enum logic [3:0] {
        S_IDLE, S_REACH, S_ERR, S_INC, S_PTERM, S_ITERM, S_DTERM, S_SUM
    } state_t;

    localparam int MCNT_W = $clog2(MUL_B_W + 1);
    localparam int DCNT_W = $clog2(DIV_W + 1);
    localparam int IW     = INTEGRAL_WIDTH;
    localparam int F      = GAIN_FRAC_BITS;
    localparam int FI     = GAIN_FRAC_BITS + 16;

    localparam logic signed [IW+1:0] IMAX = (IW+2)'((65'sd1 <<< (IW - 1)) - 65'sd1);
    localparam logic signed [IW+1:0] IMIN = -IMAX - (IW+2)'(1);

    state_t state_reg;

    // Configuration registers
    logic signed [GAIN_W-1:0] gain_p_reg, gain_i_reg, gain_d_reg;
    logic [ANGLE_W-1:0]       goal_reg;
    logic [SLEW_W-1:0]        slew_reg;

    // Controller state
    logic [ANGLE_W-1:0]        vgoal_reg;
    logic signed [ANGLE_W-1:0] last_err_reg;
    logic signed [IW-1:0]      isum_reg;

    // Per-item working registers
    logic [ANGLE_W-1:0]        heading_reg;
    logic [DT_W-1:0]           dt_reg;
    angle_diff_t               remain_reg;
    logic signed [ANGLE_W-1:0] err_reg;
    logic signed [TERM_W-1:0]  term_p_reg, term_i_reg, term_d_reg;

    // Bit-serial multiplier: {high, low} shifts right one bit per cycle
    logic [MUL_A_W-1:0] mul_a_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [MCNT_W-1:0]  mul_cnt_reg;
    logic               mul_neg_reg;

    // Bit-serial restoring divider
    logic [DIV_W-1:0]   dvd_reg;
    logic [DT_W-1:0]    drem_reg;
    logic [DCNT_W-1:0]  div_cnt_reg;
    logic               div_neg_reg;

    // Output register
    logic                      out_valid_reg;
    logic signed [DRIVE_W-1:0] drive_reg;
    logic [ABSERR_W-1:0]       abs_err_reg;

    assign req.ready     = (state_reg == S_IDLE);
    assign cfg.ready     = 1'b1;
    assign rsp.valid     = out_valid_reg;
    assign rsp.drive     = drive_reg;
    assign rsp.abs_error = abs_err_reg;

    // Multiplier step
    logic [MUL_A_W:0] mul_add;
    assign mul_add = {1'b0, prod_reg[PROD_W-1:MUL_B_W]}
                   + {1'b0, (prod_reg[0] ? mul_a_reg : '0)};

    // Divider step
    logic [DT_W:0] div_trial;
    logic          div_ge;
    assign div_trial = {drem_reg, dvd_reg[DIV_W-1]};
    assign div_ge    = (div_trial >= {1'b0, dt_reg});

    // Heading reduced into one turn
    logic [ANGLE_W-1:0] heading_in;
    assign heading_in = (req.measured_heading >= ANGLE_W'(FULL_TURN))
                      ? req.measured_heading - ANGLE_W'(FULL_TURN)
                      : req.measured_heading;

    // Slew decision from the reach product
    logic [35:0]          reach;
    logic [ANGLE_W-2:0]   remain_mag;
    logic signed [21:0]   vg_step;
    logic signed [21:0]   vg_moved;
    logic [ANGLE_W-1:0]   vg_wrapped;
    always_comb
    begin
        reach      = prod_reg[35:0];
        remain_mag = remain_reg[ANGLE_W] ? 15'(-remain_reg) : 15'(remain_reg);
        vg_step    = $signed({2'b00, reach[35:16]});
        vg_moved   = (remain_reg > 0) ? $signed({6'd0, vgoal_reg}) + vg_step
                                      : $signed({6'd0, vgoal_reg}) - vg_step;
        if (vg_moved >= 22'sd46080)
            vg_wrapped = 16'(vg_moved - 22'sd46080);
        else if (vg_moved < 0)
            vg_wrapped = 16'(vg_moved + 22'sd46080);
        else
            vg_wrapped = 16'(vg_moved);
    end

    // Error, derivative numerator
    angle_diff_t        err_new;
    logic signed [17:0] err_delta;
    logic [16:0]        delta_mag;
    logic [ANGLE_W-2:0] err_mag;
    always_comb
    begin
        err_new   = -hps_wrap($signed({1'b0, heading_reg}) - $signed({1'b0, vgoal_reg}));
        err_delta = 18'(err_new) - 18'(last_err_reg);
        delta_mag = err_delta[17] ? 17'(-err_delta) : 17'(err_delta);
        err_mag   = err_reg[ANGLE_W-1] ? 15'(-err_reg) : 15'(err_reg);
    end

    // Integral update
    logic signed [IW+1:0] inc_s;
    logic signed [IW+1:0] isum_x;
    logic signed [IW-1:0] isum_new;
    always_comb
    begin
        inc_s  = mul_neg_reg ? -$signed({2'b00, prod_reg[IW-1:0]})
                             :  $signed({2'b00, prod_reg[IW-1:0]});
        isum_x = $signed({{2{isum_reg[IW-1]}}, isum_reg}) + inc_s;
        if (isum_x > IMAX)
            isum_new = IMAX[IW-1:0];
        else if (isum_x < IMIN)
            isum_new = IMIN[IW-1:0];
        else
            isum_new = isum_x[IW-1:0];
    end

    // Floored terms at the two scalings
    logic signed [TERM_W-1:0] term_f, term_fi;
    always_comb
    begin
        term_f  = hps_term(QUOT_W'(prod_reg) >> F,  |prod_reg[F-1:0],  mul_neg_reg);
        term_fi = hps_term(QUOT_W'(prod_reg) >> FI, |prod_reg[FI-1:0], mul_neg_reg);
    end

    // Drive sum and saturation
    logic signed [SUM_W-1:0]   drive_sum;
    logic signed [DRIVE_W-1:0] drive_sat;
    always_comb
    begin
        drive_sum = SUM_W'(term_p_reg) + SUM_W'(term_i_reg) + SUM_W'(term_d_reg);
        if (drive_sum > SUM_W'(32'sh7FFFFFFF))
            drive_sat = 32'sh7FFFFFFF;
        else if (drive_sum < -SUM_W'(64'sd2147483648))
            drive_sat = -32'sh7FFFFFFF - 32'sd1;
        else
            drive_sat = drive_sum[DRIVE_W-1:0];
    end

    function automatic logic [MUL_B_W-1:0] gain_mag(input logic signed [GAIN_W-1:0] g);
        return g[GAIN_W-1] ? MUL_B_W'(-g) : MUL_B_W'(g);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            gain_p_reg    <= '0;
            gain_i_reg    <= '0;
            gain_d_reg    <= '0;
            goal_reg      <= '0;
            slew_reg      <= '0;
            vgoal_reg     <= '0;
            last_err_reg  <= '0;
            isum_reg      <= '0;
            heading_reg   <= '0;
            dt_reg        <= '0;
            remain_reg    <= '0;
            err_reg       <= '0;
            term_p_reg    <= '0;
            term_i_reg    <= '0;
            term_d_reg    <= '0;
            mul_a_reg     <= '0;
            prod_reg      <= '0;
            mul_cnt_reg   <= '0;
            mul_neg_reg   <= 1'b0;
            dvd_reg       <= '0;
            drem_reg      <= '0;
            div_cnt_reg   <= '0;
            div_neg_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            drive_reg     <= '0;
            abs_err_reg   <= '0;
        end
        else
        begin
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    REG_GAIN_P: gain_p_reg <= $signed(cfg.data);
                    REG_GAIN_I: gain_i_reg <= $signed(cfg.data);
                    REG_GAIN_D: gain_d_reg <= $signed(cfg.data);
                    REG_GOAL:
                    begin
                        if (cfg.data[15:0] >= ANGLE_W'(FULL_TURN))
                            goal_reg <= cfg.data[15:0] - ANGLE_W'(FULL_TURN);
                        else
                            goal_reg <= cfg.data[15:0];
                    end
                    REG_SLEW:   slew_reg <= cfg.data[SLEW_W-1:0];
                    default:    ;
                endcase
            end

            // In the final state the output register is handled there instead.
            if (rsp.ready && (state_reg != S_SUM))
                out_valid_reg <= 1'b0;

            if (mul_cnt_reg != '0)
            begin
                prod_reg    <= {mul_add, prod_reg[MUL_B_W-1:1]};
                mul_cnt_reg <= mul_cnt_reg - MCNT_W'(1);
            end

            if (div_cnt_reg != '0)
            begin
                drem_reg    <= div_ge ? DT_W'(div_trial - {1'b0, dt_reg}) : div_trial[DT_W-1:0];
                dvd_reg     <= {dvd_reg[DIV_W-2:0], div_ge};
                div_cnt_reg <= div_cnt_reg - DCNT_W'(1);
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        heading_reg <= heading_in;
                        dt_reg      <= req.step_time;
                        remain_reg  <= hps_wrap($signed({1'b0, goal_reg})
                                              - $signed({1'b0, vgoal_reg}));
                        mul_a_reg   <= MUL_A_W'(slew_reg);
                        prod_reg    <= PROD_W'(req.step_time);
                        mul_neg_reg <= 1'b0;
                        mul_cnt_reg <= MCNT_W'(MUL_B_W);
                        state_reg   <= S_REACH;
                    end
                end
                S_REACH:
                begin
                    if (mul_cnt_reg == '0)
                    begin
                        if ({5'd0, remain_mag, 16'd0} < reach)
                            vgoal_reg <= goal_reg;
                        else
                            vgoal_reg <= vg_wrapped;
                        state_reg <= S_ERR;
                    end
                end
                S_ERR:
                begin
                    err_reg      <= err_new[ANGLE_W-1:0];
                    last_err_reg <= err_new[ANGLE_W-1:0];
                    drem_reg     <= '0;
                    div_neg_reg  <= err_delta[17];
                    if (dt_reg != '0)
                    begin
                        dvd_reg     <= {delta_mag[15:0], 16'd0};
                        div_cnt_reg <= DCNT_W'(DIV_W);
                    end
                    else
                    begin
                        dvd_reg     <= '0;
                        div_cnt_reg <= '0;
                    end
                    mul_a_reg   <= err_new[ANGLE_W] ? MUL_A_W'(-err_new) : MUL_A_W'(err_new);
                    prod_reg    <= PROD_W'(dt_reg);
                    mul_neg_reg <= err_new[ANGLE_W];
                    mul_cnt_reg <= MCNT_W'(MUL_B_W);
                    state_reg   <= S_INC;
                end
                S_INC:
                begin
                    if (mul_cnt_reg == '0)
                    begin
                        isum_reg    <= isum_new;
                        mul_a_reg   <= MUL_A_W'(err_mag);
                        prod_reg    <= PROD_W'(gain_mag(gain_p_reg));
                        mul_neg_reg <= err_reg[ANGLE_W-1] ^ gain_p_reg[GAIN_W-1];
                        mul_cnt_reg <= MCNT_W'(MUL_B_W);
                        state_reg   <= S_PTERM;
                    end
                end
                S_PTERM:
                begin
                    if (mul_cnt_reg == '0)
                    begin
                        term_p_reg  <= term_f;
                        mul_a_reg   <= isum_reg[IW-1] ? MUL_A_W'(-isum_reg)
                                                      : MUL_A_W'(isum_reg);
                        prod_reg    <= PROD_W'(gain_mag(gain_i_reg));
                        mul_neg_reg <= isum_reg[IW-1] ^ gain_i_reg[GAIN_W-1];
                        mul_cnt_reg <= MCNT_W'(MUL_B_W);
                        state_reg   <= S_ITERM;
                    end
                end
                S_ITERM:
                begin
                    if ((mul_cnt_reg == '0) && (div_cnt_reg == '0))
                    begin
                        term_i_reg  <= term_fi;
                        mul_a_reg   <= MUL_A_W'(dvd_reg);
                        prod_reg    <= PROD_W'(gain_mag(gain_d_reg));
                        mul_neg_reg <= div_neg_reg ^ gain_d_reg[GAIN_W-1];
                        mul_cnt_reg <= MCNT_W'(MUL_B_W);
                        state_reg   <= S_DTERM;
                    end
                end
                S_DTERM:
                begin
                    if (mul_cnt_reg == '0)
                    begin
                        term_d_reg <= term_f;
                        state_reg  <= S_SUM;
                    end
                end
                S_SUM:
                begin
                    if (!out_valid_reg || rsp.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        drive_reg     <= drive_sat;
                        abs_err_reg   <= err_mag;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

@@ rtl/hps_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hps_checker: port-level checks for the heading controller
// Observes the top-level channels and flags sequencing errors.
// ----------------------------------------------------------------------------
module hps_checker
    import hps_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_ready,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input logic [ABSERR_W-1:0] rsp_abs_error
);

    // Only one item is in flight: the input closes after a transfer.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("input accepted while an item is in flight");

    // A result cannot appear in the cycle straight after an input transfer.
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready && !rsp_valid) |=> !rsp_valid)
        else $error("result appeared without computation time");

    // The wrapped error never exceeds half a turn.
    a_err_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_abs_error <= ABSERR_W'(HALF_TURN)))
        else $error("error magnitude beyond half a turn");

    // A stalled result is held.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_abs_error)))
        else $error("stalled result dropped or changed");

endmodule

bind heading_pid_with_slewed_target_top hps_checker u_hps_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_abs_error (rsp.abs_error)
);

@@ bench/hps_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hps_scoreboard: result predictor and scoreboard
// Mirrors the controller state from observed configuration writes and item
// transfers, predicts each result and compares it with the returned one.
// ----------------------------------------------------------------------------
module hps_scoreboard
    import hps_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    hps_item_if    req,
    hps_result_if  rsp,
    hps_cfg_if     cfg,
    output int     fail_count,
    output int     pending
);

    typedef struct packed {
        logic signed [31:0] drive;
        logic [14:0]        abs_error;
    } heading_result_t;

    heading_result_t expected_results[$];

    logic signed [63:0] kp, ki, kd, goal, slew;
    logic signed [63:0] vgoal, prev_err, isum;

    assign pending = expected_results.size();

    function automatic logic signed [63:0] half_wrap(input logic signed [63:0] e);
        if (e > HALF_TURN)
            return e - FULL_TURN;
        else if (e < -HALF_TURN)
            return e + FULL_TURN;
        return e;
    endfunction

    // floor(a*b / 2^sh), magnitude clamped at 2^61.
    function automatic logic signed [63:0] scaled_product(input logic signed [63:0] a,
                                                          input logic signed [63:0] b,
                                                          input int sh);
        logic signed [127:0] p;
        logic signed [127:0] q;
        logic signed [127:0] lim;
        p   = 128'(a) * 128'(b);
        q   = p >>> sh;
        lim = 128'sd1 <<< 61;
        if (q > lim)
            q = lim;
        else if (q < -lim)
            q = -lim;
        return q[63:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic signed [63:0] dt, hdg, remaining, reach, mag, err, rate, inc, drv;
        logic signed [63:0] imax, imin, ndiff;
        heading_result_t got, exp_res;
        if (!rst_n)
        begin
            kp = 0; ki = 0; kd = 0; goal = 0; slew = 0;
            vgoal = 0; prev_err = 0; isum = 0;
            fail_count <= 0;
            expected_results.delete();
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_GAIN_P: kp = 64'($signed(cfg.data));
                    REG_GAIN_I: ki = 64'($signed(cfg.data));
                    REG_GAIN_D: kd = 64'($signed(cfg.data));
                    REG_GOAL:
                    begin
                        goal = 64'(cfg.data[15:0]);
                        if (goal >= FULL_TURN)
                            goal -= FULL_TURN;
                    end
                    REG_SLEW: slew = 64'(cfg.data[19:0]);
                    default: ;
                endcase
            end
            if (req.valid && req.ready)
            begin
                dt  = 64'(req.step_time);
                hdg = 64'(req.measured_heading);
                if (hdg >= FULL_TURN)
                    hdg -= FULL_TURN;
                remaining = half_wrap(goal - vgoal);
                reach = slew * dt;
                mag = remaining < 0 ? -remaining : remaining;
                if (mag * 65536 < reach)
                    vgoal = goal;
                else
                begin
                    vgoal = remaining > 0 ? vgoal + (reach >>> 16) : vgoal - (reach >>> 16);
                    if (vgoal >= FULL_TURN)
                        vgoal -= FULL_TURN;
                    else if (vgoal < 0)
                        vgoal += FULL_TURN;
                end
                err = -half_wrap(hdg - vgoal);
                // Division truncating toward zero, as the hardware divider does.
                ndiff = (err - prev_err) * 65536;
                rate = dt != 0 ? ndiff / dt : 0;
                prev_err = err;
                imax = (64'sd1 <<< (INTEGRAL_WIDTH - 1)) - 1;
                imin = -imax - 1;
                inc = err * dt;
                if (inc > 0 && isum > imax - inc)
                    isum = imax;
                else if (inc < 0 && isum < imin - inc)
                    isum = imin;
                else
                    isum += inc;
                drv = scaled_product(kp, err, GAIN_FRAC_BITS)
                    + scaled_product(ki, isum, GAIN_FRAC_BITS + 16)
                    + scaled_product(kd, rate, GAIN_FRAC_BITS);
                if (drv > 64'sd2147483647)
                    drv = 64'sd2147483647;
                else if (drv < -64'sd2147483648)
                    drv = -64'sd2147483648;
                exp_res.drive = drv[31:0];
                exp_res.abs_error = 15'(err < 0 ? -err : err);
                expected_results.push_back(exp_res);
            end
            if (rsp.valid && rsp.ready)
            begin
                got.drive = rsp.drive;
                got.abs_error = rsp.abs_error;
                if (expected_results.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected result: drive %0d abs_error %0d",
                                 got.drive, got.abs_error);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_res = expected_results.pop_front();
                    if (got != exp_res)
                    begin
                        if (fail_count < 10)
                            $display("mismatch: drive exp %0d got %0d, abs_error exp %0d got %0d",
                                     exp_res.drive, got.drive, exp_res.abs_error, got.abs_error);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: heading PID controller testbench
// Drives directed and random heading updates through several gain, goal and
// slew settings, with random idling on both channels; the checker predicts
// and compares every result.
// ----------------------------------------------------------------------------
module tb;
    import hps_pkg::*;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    // Idling is switched off for one long stretch in the middle of the run.
    bit   steady;
    bit   hold_off;

    hps_item_if   req ();
    hps_result_if rsp ();
    hps_cfg_if    cfg ();

    heading_pid_with_slewed_target_top u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg)
    );

    hps_scoreboard u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .rsp        (rsp),
        .cfg        (cfg),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Generous cap on the run time, allowing for stalls on both sides.
    initial
    begin
        #400ms;
        $display("CHECKS FAILED");
        $finish;
    end

    // The receiver stalls at random, except while steady or during a hold-off.
    initial
    begin
        rsp.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off)
                rsp.ready <= 1'b0;
            else
                rsp.ready <= steady || ($urandom_range(0, 99) >= 33);
        end
    end

    // One item transfer, with a random gap in front of it unless steady.
    // Valid stays up after the transfer; drain lowers it, the next call only for a gap.
    task automatic send_update(input logic [15:0] dt, input logic [15:0] hdg);
        while (!steady && $urandom_range(0, 99) < 33)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid            <= 1'b1;
        req.step_time        <= dt;
        req.measured_heading <= hdg;
        do
            @(posedge clk);
        while (!req.ready);
    endtask

    // Valid stays up after the write; set_all lowers it after the last one.
    task automatic write_reg(input logic [2:0] idx, input logic [23:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        do
            @(posedge clk);
        while (!cfg.ready);
    endtask

    // Waits for every outstanding result, then lets the block settle.
    task automatic drain;
        req.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);
    endtask

    task automatic set_all(input logic [23:0] p, input logic [23:0] i, input logic [23:0] d,
                           input logic [15:0] g, input logic [19:0] s);
        drain();
        write_reg(REG_GAIN_P, p);
        write_reg(REG_GAIN_I, i);
        write_reg(REG_GAIN_D, d);
        write_reg(REG_GOAL, 24'(g));
        write_reg(REG_SLEW, 24'(s));
        cfg.valid <= 1'b0;
    endtask

    function automatic logic [23:0] rand_gain();
        case ($urandom_range(0, 4))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return 24'($urandom_range(0, 2047)) - 24'd1024;
            default: return 24'($urandom);
        endcase
    endfunction

    // Mostly headings along a slowly stepping track, some anywhere, rare out-of-range ones.
    task automatic random_phase(input int n);
        logic [15:0] dt, hdg;
        for (int k = 0; k < n; k++)
        begin
            case ($urandom_range(0, 9))
                0:       dt = 16'($urandom);
                1:       dt = 16'd0;
                2, 3:    dt = 16'($urandom_range(1, 64));
                default: dt = 16'($urandom_range(1, 2000));
            endcase
            case ($urandom_range(0, 9))
                0:       hdg = 16'($urandom);
                1, 2:    hdg = 16'($urandom_range(0, 46079));
                default: hdg = 16'(($urandom_range(0, 46079) % 400)
                                   + (k * 37 % 46080)) % 16'd46080;
            endcase
            send_update(dt, hdg);
        end
    endtask

    initial
    begin
        int held;
        steady     = 1'b0;
        hold_off   = 1'b0;
        rst_n      = 1'b0;
        req.valid  = 1'b0;
        req.step_time = '0;
        req.measured_heading = '0;
        cfg.valid  = 1'b0;
        cfg.index  = '0;
        cfg.data   = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes, half-turn error, wrap of the goal,
        // zero step time, out-of-range angles and saturating gains.
        set_all(24'h010000, 24'h008000, 24'h000100, 16'd46079, 20'hFFFFF);
        send_update(16'd1, 16'd0);
        send_update(16'd65535, 16'd23040);
        send_update(16'd0, 16'd46079);
        send_update(16'd0, 16'hFFFF);
        send_update(16'd1, 16'd46080);
        set_all(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 16'hFFFF, 20'd0);
        send_update(16'd65535, 16'd23039);
        send_update(16'd65535, 16'd23039);
        send_update(16'd1, 16'd0);
        set_all(24'h800000, 24'h800000, 24'h800000, 16'd23040, 20'd128);
        send_update(16'd65535, 16'd0);
        send_update(16'd65535, 16'd46079);
        send_update(16'd1, 16'd23040);
        send_update(16'd0, 16'd11520);
        send_update(16'd32768, 16'd34560);
        set_all(24'h000000, 24'h000001, 24'hFFFFFF, 16'd0, 20'd46080);
        send_update(16'd65535, 16'd0);
        send_update(16'd65535, 16'd46079);
        send_update(16'd1, 16'd1);

        // Random phases with fresh settings; the sender pauses for all
        // results before each reconfiguration.
        for (int ph = 0; ph < 6; ph++)
        begin
            set_all(rand_gain(), rand_gain(), rand_gain(), 16'($urandom),
                    20'($urandom_range(0, 3)) == 0 ? 20'($urandom) : 20'($urandom_range(0, 60000)));
            if (ph == 2)
            begin
                steady = 1'b1;
                random_phase(100);
                steady = 1'b0;
            end
            else if (ph == 4)
            begin
                // Long receiver hold-off while items keep being offered.
                hold_off = 1'b1;
                fork
                    begin
                        held = 0;
                        while (held < 600)
                        begin
                            @(posedge clk);
                            held++;
                        end
                        hold_off = 1'b0;
                    end
                    random_phase(20);
                join
            end
            random_phase(240);
        end

        drain();
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/hps_pkg.sv
rtl/hps_item_if.sv
rtl/hps_result_if.sv
rtl/hps_cfg_if.sv
rtl/heading_pid_with_slewed_target_top.sv
rtl/hps_checker.sv
bench/hps_checker.sv
bench/tb.sv
